[hdl/reader_frame_receiver_core_defines.svh]
// Assertion macros for the reader frame receiver port checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef READER_FRAME_RECEIVER_CORE_DEFINES_SVH
`define READER_FRAME_RECEIVER_CORE_DEFINES_SVH

// Check a property on every rising edge, quiet while reset is low.
`define RFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RFR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hdl/rfr_pkg.sv]
// Types, constants and helper functions of the reader frame receiver.
// Used by the configuration, parser, output stage and top-level files.
`default_nettype none

package rfr_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] RegSlotChange = 2'd0;
  localparam logic [1:0] RegHwError    = 2'd1;
  localparam logic [1:0] RegKeyEvent   = 2'd2;
  localparam logic [1:0] RegMaxFrame   = 2'd3;

  localparam logic [7:0]  SlotChangeReset = 8'd80;
  localparam logic [7:0]  HwErrorReset    = 8'd81;
  localparam logic [7:0]  KeyEventReset   = 8'd64;
  localparam logic [16:0] MaxFrameReset   = 17'd65545;

  // Report status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNak     = 2'd1;
  localparam logic [1:0] StatusTooLong = 2'd2;

  localparam logic [7:0] AckByte = 8'hFF;
  localparam logic [7:0] NakByte = 8'h00;

  localparam logic [16:0] HeaderBytes    = 17'd10;
  localparam logic [16:0] LastHeaderIdx  = 17'd9;
  localparam logic [16:0] IntrFrameBytes = 17'd2;
  localparam logic [16:0] AckFrameBytes  = 17'd1;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_SUM    = 5'b01000,
    PH_XOR    = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    FT_HEADER = 2'd0,
    FT_INTR   = 2'd1,
    FT_ACK    = 2'd2
  } frame_type_e;

  typedef struct packed {
    logic [7:0]  slot_change_code;
    logic [7:0]  hw_error_code;
    logic [7:0]  key_event_code;
    logic [16:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic        checksum_ok;
    logic        send_ack;
    logic [7:0]  ack_byte;
    logic [16:0] frame_length;
    logic        is_interrupt;
  } result_t;

  function automatic logic [16:0] frame_total(frame_type_e ft, logic [15:0] body_len);
    logic [16:0] tot;
    case (ft)
      FT_INTR: tot = IntrFrameBytes;
      FT_ACK:  tot = AckFrameBytes;
      default: tot = HeaderBytes + {1'b0, body_len};
    endcase
    return tot;
  endfunction

  function automatic result_t make_byte(logic [7:0] b);
    result_t r;
    r      = '0;
    r.data = b;
    return r;
  endfunction

  function automatic result_t make_report(logic [1:0] status, logic ok, logic ack,
                                          logic [7:0] ackb, logic [16:0] len,
                                          logic intr);
    result_t r;
    r              = '0;
    r.kind         = 1'b1;
    r.status       = status;
    r.checksum_ok  = ok;
    r.send_ack     = ack;
    r.ack_byte     = ackb;
    r.frame_length = len;
    r.is_interrupt = intr;
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/reader_frame_receiver_core.sv]
// Top level of the reader frame receiver: input register, parser, result register
// and configuration port. Depends on rfr_pkg, rfr_cfg_regs, rfr_parser, rfr_out_stage.
//
//   channel   | direction | handshake                      | payload
//   ----------+-----------+--------------------------------+----------------------------
//   s_axis    | in        | s_axis_tvalid / s_axis_tready  | received byte
//   m_axis    | out       | m_axis_tvalid / m_axis_tready  | message byte or end report
//   apb       | in        | psel & penable & pwrite        | frame codes, length limit
//
// A request sits in the input register while the parser step works on it; its result
// enters the result register when the step is taken, and m_axis_tvalid is driven from
// the result register. The first check byte leaves no result. One byte per cycle is
// sustained while m_axis_tready stays high; the parser state update is the only loop.
// Reset (rst_ni low, asynchronous) clears the phase to idle, empties both registers
// and restores the register defaults. A stall on m_axis holds the result register,
// then the input register; s_axis_tready drops only when both are full and
// m_axis_tready is low.
`default_nettype none

module reader_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] data, [9:8] status, [10] checksum_ok,
                                           // [11] send_ack, [19:12] ack_byte,
                                           // [36:20] frame_length, [37] is_interrupt,
                                           // [39:38] zero
  output logic             m_axis_tuser,   // [0] kind
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rfr_pkg::cfg_t    cfg;
  rfr_pkg::result_t step_res, out_res;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             s_accept, step, step_res_valid, out_can_load;

  rfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the parser whenever a byte waits and the result register can take its output
  assign step          = in_valid_q && out_can_load;
  assign s_axis_tready = !in_valid_q || step;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  rfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  // The first check byte gives no result; drop it here
  rfr_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && step_res_valid),
    .res_i      (step_res),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {2'b00, out_res.is_interrupt, out_res.frame_length,
                         out_res.ack_byte, out_res.send_ack, out_res.checksum_ok,
                         out_res.status, out_res.data};

endmodule

`default_nettype wire

[hdl/rfr_cfg_regs.sv]
// APB-style configuration registers of the reader frame receiver.
// Depends on rfr_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module rfr_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output rfr_pkg::cfg_t      cfg_o
);

  rfr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rfr_pkg::RegSlotChange: cfg_d.slot_change_code = pwdata[7:0];
        rfr_pkg::RegHwError:    cfg_d.hw_error_code    = pwdata[7:0];
        rfr_pkg::RegKeyEvent:   cfg_d.key_event_code   = pwdata[7:0];
        rfr_pkg::RegMaxFrame:   cfg_d.max_frame_bytes  = pwdata[16:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rfr_pkg::RegSlotChange: prdata = {24'd0, cfg_q.slot_change_code};
      rfr_pkg::RegHwError:    prdata = {24'd0, cfg_q.hw_error_code};
      rfr_pkg::RegKeyEvent:   prdata = {24'd0, cfg_q.key_event_code};
      rfr_pkg::RegMaxFrame:   prdata = {15'd0, cfg_q.max_frame_bytes};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_change_code <= rfr_pkg::SlotChangeReset;
      cfg_q.hw_error_code    <= rfr_pkg::HwErrorReset;
      cfg_q.key_event_code   <= rfr_pkg::KeyEventReset;
      cfg_q.max_frame_bytes  <= rfr_pkg::MaxFrameReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/rfr_parser.sv]
// Frame parser: phase machine, byte counter, body length and checksums.
// One byte is processed per step; depends on rfr_pkg.
`default_nettype none

module rfr_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire rfr_pkg::cfg_t    cfg_i,
  output logic                  res_valid_o,
  output rfr_pkg::result_t      res_o
);

  rfr_pkg::phase_e      phase_q, phase_d;
  rfr_pkg::frame_type_e ftype_q, ftype_d, ft_new;
  logic [16:0]          count_q, count_d, count_inc, tot;
  logic [15:0]          body_len_q, body_len_d, bl_new;
  logic [7:0]           sum_q, sum_d, xor_q, xor_d, rx_sum_q, rx_sum_d;
  logic                 ok;

  assign count_inc = count_q + 17'd1;

  always_comb begin
    if (byte_i == cfg_i.slot_change_code || byte_i == cfg_i.hw_error_code ||
        byte_i == cfg_i.key_event_code) begin
      ft_new = rfr_pkg::FT_INTR;
    end else if (byte_i == rfr_pkg::NakByte || byte_i == rfr_pkg::AckByte) begin
      ft_new = rfr_pkg::FT_ACK;
    end else begin
      ft_new = rfr_pkg::FT_HEADER;
    end
  end

  // Header bytes 1 and 2 carry the body length, low byte first
  always_comb begin
    bl_new = body_len_q;
    if (count_q == 17'd1) bl_new[7:0] = byte_i;
    else if (count_q == 17'd2) bl_new[15:8] = byte_i;
  end

  assign ok = (rx_sum_q == sum_q) && (byte_i == xor_q);

  always_comb begin
    phase_d     = phase_q;
    ftype_d     = ftype_q;
    count_d     = count_q;
    body_len_d  = body_len_q;
    sum_d       = sum_q;
    xor_d       = xor_q;
    rx_sum_d    = rx_sum_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    tot         = '0;
    case (phase_q)
      rfr_pkg::PH_IDLE: begin
        ftype_d    = ft_new;
        body_len_d = '0;
        rx_sum_d   = '0;
        tot        = rfr_pkg::frame_total(ft_new, 16'd0);
        res_valid_o = 1'b1;
        if (ft_new != rfr_pkg::FT_HEADER && tot > cfg_i.max_frame_bytes) begin
          count_d = '0;
          sum_d   = '0;
          xor_d   = '0;
          res_o   = rfr_pkg::make_report(rfr_pkg::StatusTooLong, 1'b0, 1'b0,
                                         rfr_pkg::NakByte, tot,
                                         ft_new == rfr_pkg::FT_INTR);
        end else begin
          count_d = 17'd1;
          sum_d   = byte_i;
          xor_d   = byte_i;
          res_o   = rfr_pkg::make_byte(byte_i);
          case (ft_new)
            rfr_pkg::FT_INTR: phase_d = rfr_pkg::PH_BODY;
            rfr_pkg::FT_ACK:  phase_d = rfr_pkg::PH_SUM;
            default:          phase_d = rfr_pkg::PH_HEADER;
          endcase
        end
      end
      rfr_pkg::PH_HEADER: begin
        body_len_d  = bl_new;
        tot         = rfr_pkg::frame_total(rfr_pkg::FT_HEADER, bl_new);
        res_valid_o = 1'b1;
        if (count_q >= rfr_pkg::LastHeaderIdx && tot > cfg_i.max_frame_bytes) begin
          phase_d = rfr_pkg::PH_IDLE;
          res_o   = rfr_pkg::make_report(rfr_pkg::StatusTooLong, 1'b0, 1'b0,
                                         rfr_pkg::NakByte, tot, 1'b0);
        end else begin
          count_d = count_inc;
          sum_d   = sum_q + byte_i;
          xor_d   = xor_q ^ byte_i;
          res_o   = rfr_pkg::make_byte(byte_i);
          if (count_q >= rfr_pkg::LastHeaderIdx) begin
            phase_d = (bl_new == 16'd0) ? rfr_pkg::PH_SUM : rfr_pkg::PH_BODY;
          end
        end
      end
      rfr_pkg::PH_BODY: begin
        tot         = rfr_pkg::frame_total(ftype_q, body_len_q);
        count_d     = count_inc;
        sum_d       = sum_q + byte_i;
        xor_d       = xor_q ^ byte_i;
        res_valid_o = 1'b1;
        res_o       = rfr_pkg::make_byte(byte_i);
        if (count_inc >= tot) phase_d = rfr_pkg::PH_SUM;
      end
      rfr_pkg::PH_SUM: begin
        rx_sum_d = byte_i;
        phase_d  = rfr_pkg::PH_XOR;
      end
      rfr_pkg::PH_XOR: begin
        tot         = rfr_pkg::frame_total(ftype_q, body_len_q);
        phase_d     = rfr_pkg::PH_IDLE;
        res_valid_o = 1'b1;
        if (ftype_q == rfr_pkg::FT_INTR) begin
          res_o = rfr_pkg::make_report(rfr_pkg::StatusOk, ok, 1'b0,
                                       rfr_pkg::NakByte, tot, 1'b1);
        end else begin
          res_o = rfr_pkg::make_report(ok ? rfr_pkg::StatusOk : rfr_pkg::StatusNak,
                                       ok, 1'b1,
                                       ok ? rfr_pkg::AckByte : rfr_pkg::NakByte,
                                       tot, 1'b0);
        end
      end
      default: begin
        phase_d = rfr_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rfr_pkg::PH_IDLE;
      ftype_q    <= rfr_pkg::FT_HEADER;
      count_q    <= '0;
      body_len_q <= '0;
      sum_q      <= '0;
      xor_q      <= '0;
      rx_sum_q   <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      ftype_q    <= ftype_d;
      count_q    <= count_d;
      body_len_q <= body_len_d;
      sum_q      <= sum_d;
      xor_q      <= xor_d;
      rx_sum_q   <= rx_sum_d;
    end
  end

endmodule

`default_nettype wire

[hdl/rfr_out_stage.sv]
// Result register between the parser and the output stream.
// Holds one result until taken; depends on rfr_pkg for result_t.
`default_nettype none

module rfr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire rfr_pkg::result_t  res_i,
  output logic                   can_load_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rfr_pkg::result_t       res_o
);

  logic             valid_q;
  rfr_pkg::result_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign can_load_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[hdl/rfr_port_checker.sv]
// Port-level checker for the reader frame receiver, bound to its top level.
// Depends on reader_frame_receiver_core_defines.svh for the macros and rfr_pkg for codes.
`default_nettype none
`include "reader_frame_receiver_core_defines.svh"

module rfr_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic byte_v;
  logic rep_v;
  logic ack_sent;
  logic ack_ff;
  logic sum_ok;
  logic too_long;

  assign byte_v   = m_axis_tvalid && !m_axis_tuser;
  assign rep_v    = m_axis_tvalid && m_axis_tuser;
  assign ack_sent = m_axis_tdata[11];
  assign ack_ff   = (m_axis_tdata[19:12] == rfr_pkg::AckByte);
  assign sum_ok   = m_axis_tdata[10];
  assign too_long = (m_axis_tdata[9:8] == rfr_pkg::StatusTooLong);

  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser);
  endproperty

  // A stalled result holds
  `RFR_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

  // Forwarded bytes carry nothing beyond the byte itself
  `RFR_ASSERT_IMPL(a_byte_clean, byte_v, m_axis_tdata[39:8] == 32'd0, "report bits on a byte")

  // An acknowledge answers a good frame, a negative acknowledge a bad one
  `RFR_ASSERT_IMPL(a_ack_match, rep_v && ack_sent, ack_ff == sum_ok, "ack byte vs checksum")

  // A frame cut for length gets no answer and no checksum verdict
  `RFR_ASSERT_IMPL(a_too_long, rep_v && too_long, !ack_sent && !sum_ok, "cut frame answered")

endmodule

bind reader_frame_receiver_core rfr_port_checker u_rfr_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// Stream test of reader_frame_receiver_core: sends framed serial bytes, checks each
// forwarded byte and end report against a built-in frame parser. Depends on rfr_pkg, RTL.
module tb;

  localparam int CycleLimit  = 1_000_000;
  localparam int RandomBytes = 1150;
  localparam int MaxWait     = 14;
  localparam int DrainCycles = 16;

  // How the two check bytes of a generated frame are formed
  typedef enum int {
    ChkGood,
    ChkBadSum,
    ChkBadXor,
    ChkBadBoth,
    ChkRandom
  } chk_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Parser copy: configuration plus frame state, advanced once per accepted request
  rfr_pkg::cfg_t        cfg      = {rfr_pkg::SlotChangeReset, rfr_pkg::HwErrorReset,
                                    rfr_pkg::KeyEventReset, rfr_pkg::MaxFrameReset};
  rfr_pkg::phase_e      ph       = rfr_pkg::PH_IDLE;
  rfr_pkg::frame_type_e ftype    = rfr_pkg::FT_HEADER;
  logic [16:0]          nbytes   = '0;
  logic [15:0]          body_len = '0;
  logic [7:0]           run_sum  = '0;
  logic [7:0]           run_xor  = '0;
  logic [7:0]           got_sum  = '0;

  // Forwarded bytes and end reports still owed by the core, oldest first
  rfr_pkg::result_t     byte_report_q[$];

  int n_err    = 0;
  int cycles   = 0;
  int rx_count = 0;
  int rx_wait  = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  reader_frame_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Frame parser
  // ---------------------------------------------------------------------------

  // Message length announced by the current frame (header plus body)
  function automatic logic [16:0] announced_len();
    case (ftype)
      rfr_pkg::FT_INTR: return rfr_pkg::IntrFrameBytes;
      rfr_pkg::FT_ACK:  return rfr_pkg::AckFrameBytes;
      default:          return rfr_pkg::HeaderBytes + {1'b0, body_len};
    endcase
  endfunction

  function automatic void fold(logic [7:0] b);
    run_sum = run_sum + b;
    run_xor = run_xor ^ b;
    nbytes  = nbytes + 17'd1;
  endfunction

  function automatic rfr_pkg::result_t end_report(logic [1:0] st, logic ok, logic ack,
                                                  logic [7:0] ab);
    rfr_pkg::result_t r;
    r              = '0;
    r.kind         = 1'b1;
    r.status       = st;
    r.checksum_ok  = ok;
    r.send_ack     = ack;
    r.ack_byte     = ab;
    r.frame_length = announced_len();
    r.is_interrupt = (ftype == rfr_pkg::FT_INTR);
    return r;
  endfunction

  // Advance the parser by one received byte and queue what the core must emit for it
  task automatic parse_rx_byte(input logic [7:0] b);
    rfr_pkg::result_t r;
    bit               emit;
    logic             ok;
    r      = '0;
    r.data = b;
    emit   = 1'b1;
    case (ph)
      rfr_pkg::PH_IDLE: begin
        nbytes   = '0;
        body_len = '0;
        run_sum  = '0;
        run_xor  = '0;
        got_sum  = '0;
        // interrupt codes win over the bare ack values
        if (b == cfg.slot_change_code || b == cfg.hw_error_code ||
            b == cfg.key_event_code)
          ftype = rfr_pkg::FT_INTR;
        else if (b == rfr_pkg::NakByte || b == rfr_pkg::AckByte)
          ftype = rfr_pkg::FT_ACK;
        else
          ftype = rfr_pkg::FT_HEADER;
        if (ftype != rfr_pkg::FT_HEADER && announced_len() > cfg.max_frame_bytes) begin
          r = end_report(rfr_pkg::StatusTooLong, 1'b0, 1'b0, rfr_pkg::NakByte);
        end else begin
          fold(b);
          if (ftype == rfr_pkg::FT_INTR) ph = rfr_pkg::PH_BODY;
          else if (ftype == rfr_pkg::FT_ACK) ph = rfr_pkg::PH_SUM;
          else ph = rfr_pkg::PH_HEADER;
        end
      end
      rfr_pkg::PH_HEADER: begin
        if (nbytes == 17'd1) body_len[7:0] = b;
        else if (nbytes == 17'd2) body_len[15:8] = b;
        if (nbytes >= rfr_pkg::LastHeaderIdx) begin
          // length known: drop the last header byte if the frame is over the limit
          if (announced_len() > cfg.max_frame_bytes) begin
            r  = end_report(rfr_pkg::StatusTooLong, 1'b0, 1'b0, rfr_pkg::NakByte);
            ph = rfr_pkg::PH_IDLE;
          end else begin
            fold(b);
            if (body_len == 16'd0) ph = rfr_pkg::PH_SUM;
            else ph = rfr_pkg::PH_BODY;
          end
        end else begin
          fold(b);
        end
      end
      rfr_pkg::PH_BODY: begin
        fold(b);
        if (nbytes >= announced_len()) ph = rfr_pkg::PH_SUM;
      end
      rfr_pkg::PH_SUM: begin
        got_sum = b;
        ph      = rfr_pkg::PH_XOR;
        emit    = 1'b0;
      end
      default: begin
        ok = (got_sum == run_sum) && (b == run_xor);
        ph = rfr_pkg::PH_IDLE;
        if (ftype == rfr_pkg::FT_INTR)
          r = end_report(rfr_pkg::StatusOk, ok, 1'b0, rfr_pkg::NakByte);
        else if (ok)
          r = end_report(rfr_pkg::StatusOk, 1'b1, 1'b1, rfr_pkg::AckByte);
        else
          r = end_report(rfr_pkg::StatusNak, 1'b0, 1'b1, rfr_pkg::NakByte);
      end
    endcase
    if (emit) byte_report_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall, sample and compare
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    n_err++;
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [39:0] got, input logic [39:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    rfr_pkg::result_t got;
    rfr_pkg::result_t want;
    got              = '0;
    got.kind         = m_axis_tuser;
    got.data         = m_axis_tdata[7:0];
    got.status       = m_axis_tdata[9:8];
    got.checksum_ok  = m_axis_tdata[10];
    got.send_ack     = m_axis_tdata[11];
    got.ack_byte     = m_axis_tdata[19:12];
    got.frame_length = m_axis_tdata[36:20];
    got.is_interrupt = m_axis_tdata[37];
    if (byte_report_q.size() == 0) begin
      report_mismatch("output with nothing pending", m_axis_tdata, '0);
      return;
    end
    want = byte_report_q.pop_front();
    check_field("kind", 40'(got.kind), 40'(want.kind));
    check_field("data", 40'(got.data), 40'(want.data));
    check_field("status", 40'(got.status), 40'(want.status));
    check_field("checksum_ok", 40'(got.checksum_ok), 40'(want.checksum_ok));
    check_field("send_ack", 40'(got.send_ack), 40'(want.send_ack));
    check_field("ack_byte", 40'(got.ack_byte), 40'(want.ack_byte));
    check_field("frame_length", 40'(got.frame_length), 40'(want.frame_length));
    check_field("is_interrupt", 40'(got.is_interrupt), 40'(want.is_interrupt));
    check_field("tdata padding", 40'(m_axis_tdata[39:38]), '0);
  endtask

  // Sample at the falling edge: everything driven at the rising edge has settled, and a
  // valid/ready pair seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result();
      // draw the stall that follows this request
      rx_wait = rx_burst ? 0 : $urandom_range(0, MaxWait);
    end
  end

  // Hold ready low for the drawn number of cycles after each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and configuration
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap, wait for the request to be taken, then predict.
  // Valid stays high on return so a zero gap keeps the stream back to back.
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    rx_count++;
    parse_rx_byte(b);
  endtask

  // Drop valid, drain every owed output, then cover a trailing check byte still in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (byte_report_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rfr_pkg::RegSlotChange: cfg.slot_change_code = value[7:0];
      rfr_pkg::RegHwError:    cfg.hw_error_code    = value[7:0];
      rfr_pkg::RegKeyEvent:   cfg.key_event_code   = value[7:0];
      default:                cfg.max_frame_bytes  = value[16:0];
    endcase
    // an idle wait with psel low keeps back-to-back writes from colliding on psel
    @(posedge clk_i);
  endtask

  // Send a whole frame, letting the parser state pick each following byte: bytes 1 and 2
  // of a header carry len, check bytes follow chk.
  task automatic send_frame(input logic [7:0] first, input logic [15:0] len,
                            input chk_mode_e chk);
    logic [7:0] b;
    send_rx_byte(first);
    while (ph != rfr_pkg::PH_IDLE) begin
      case (ph)
        rfr_pkg::PH_HEADER: begin
          if (nbytes == 17'd1) b = len[7:0];
          else if (nbytes == 17'd2) b = len[15:8];
          else b = 8'($urandom_range(0, 255));
        end
        rfr_pkg::PH_SUM: begin
          if (chk == ChkRandom) b = 8'($urandom_range(0, 255));
          else if (chk == ChkBadSum || chk == ChkBadBoth)
            b = run_sum ^ 8'($urandom_range(1, 255));
          else b = run_sum;
        end
        rfr_pkg::PH_XOR: begin
          if (chk == ChkRandom) b = 8'($urandom_range(0, 255));
          else if (chk == ChkBadXor || chk == ChkBadBoth)
            b = run_xor ^ 8'($urandom_range(1, 255));
          else b = run_xor;
        end
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_rx_byte(b);
    end
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return rfr_pkg::NakByte;
      1:       return rfr_pkg::AckByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default codes: bare acks, an interrupt with a bad XOR, an empty header frame
  task automatic test_reset_defaults();
    send_frame(rfr_pkg::NakByte, 16'd0, ChkGood);
    send_frame(rfr_pkg::AckByte, 16'd0, ChkBadSum);
    send_frame(rfr_pkg::HwErrorReset, 16'd0, ChkBadXor);
    send_frame(8'h12, 16'd0, ChkGood);
  endtask

  // Interrupt codes equal to 0x00 and 0xFF turn those bytes into interrupt starts
  task automatic test_code_overlap();
    settle();
    write_reg(rfr_pkg::RegSlotChange, 32'(rfr_pkg::NakByte));
    write_reg(rfr_pkg::RegHwError, 32'(rfr_pkg::AckByte));
    write_reg(rfr_pkg::RegKeyEvent, 32'h7F);
    send_frame(rfr_pkg::NakByte, 16'd0, ChkGood);
    send_frame(rfr_pkg::AckByte, 16'd0, ChkBadSum);
  endtask

  // Frames over the length limit, including a zero limit that rejects everything
  task automatic test_length_limit();
    settle();
    write_reg(rfr_pkg::RegMaxFrame, 32'd1);
    send_frame(8'h00 ^ 8'h01, 16'd0, ChkGood);  // 0x01 is a header start, cut at byte 9
    send_frame(8'h7F, 16'd0, ChkGood);          // interrupt of 2 bytes over a limit of 1
    settle();
    write_reg(rfr_pkg::RegSlotChange, 32'(rfr_pkg::SlotChangeReset));
    write_reg(rfr_pkg::RegHwError, 32'(rfr_pkg::HwErrorReset));
    send_frame(rfr_pkg::AckByte, 16'd0, ChkGood);  // a bare ack just fits
    settle();
    write_reg(rfr_pkg::RegMaxFrame, 32'(rfr_pkg::MaxFrameReset) - 32'd1);
    send_frame(8'h33, 16'hFFFF, ChkGood);
    settle();
    write_reg(rfr_pkg::RegMaxFrame, 32'd0);
    send_frame(rfr_pkg::NakByte, 16'd0, ChkGood);
  endtask

  // A header frame exactly at the limit passes; with the limit one lower it is cut
  task automatic test_exact_limit();
    settle();
    write_reg(rfr_pkg::RegKeyEvent, 32'(rfr_pkg::KeyEventReset));
    write_reg(rfr_pkg::RegMaxFrame, 32'd110);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_frame(8'h20, 16'd100, ChkGood);
    settle();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    write_reg(rfr_pkg::RegMaxFrame, 32'd109);
    send_frame(8'h20, 16'd100, ChkGood);
    settle();
    write_reg(rfr_pkg::RegMaxFrame, 32'(rfr_pkg::MaxFrameReset));
  endtask

  // Mostly well-formed frames with random content and check errors, some noise frames,
  // and fresh codes and limits between bursts of traffic
  task automatic test_random_traffic();
    int          start;
    int          pick;
    logic [7:0]  first;
    logic [15:0] len;
    logic [16:0] lim;
    chk_mode_e   chk;
    start = rx_count;
    while (rx_count - start < RandomBytes) begin
      if ($urandom_range(0, 14) == 0) begin
        settle();
        case ($urandom_range(0, 5))
          0:       lim = '0;
          1:       lim = 17'($urandom_range(1, 3));
          2:       lim = 17'($urandom_range(9, 12));
          3:       lim = 17'($urandom_range(13, 40));
          4:       lim = rfr_pkg::MaxFrameReset;
          default: lim = 17'($urandom_range(1, 65545));
        endcase
        write_reg(rfr_pkg::RegSlotChange, 32'(pick_code()));
        write_reg(rfr_pkg::RegHwError, 32'(pick_code()));
        write_reg(rfr_pkg::RegKeyEvent, 32'(pick_code()));
        write_reg(rfr_pkg::RegMaxFrame, 32'(lim));
      end
      if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
      if ($urandom_range(0, 9) == 0) rx_burst = !rx_burst;
      if ($urandom_range(0, 19) == 0) len = 16'($urandom_range(25, 200));
      else len = 16'($urandom_range(0, 24));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: chk = ChkGood;
        7:       chk = ChkBadSum;
        8:       chk = ChkBadXor;
        default: chk = ChkBadBoth;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        case ($urandom_range(0, 2))
          0:       first = cfg.slot_change_code;
          1:       first = cfg.hw_error_code;
          default: first = cfg.key_event_code;
        endcase
      end else if (pick == 2) begin
        first = $urandom_range(0, 1) ? rfr_pkg::AckByte : rfr_pkg::NakByte;
      end else begin
        first = 8'($urandom_range(0, 255));
        if (pick == 9) chk = ChkRandom;  // noise: random start and random check bytes
      end
      send_frame(first, len, chk);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_code_overlap();
    test_length_limit();
    test_exact_limit();
    test_random_traffic();
    settle();
    if (n_err == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
